// File: src/triangle_plane_clipper_defines.svh
// ---------------------------------------------------------------------------
// Triangle plane clipper assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef TRIANGLE_PLANE_CLIPPER_DEFINES_SVH
`define TRIANGLE_PLANE_CLIPPER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define TPC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/tpc_pkg.sv
// ---------------------------------------------------------------------------
// Triangle plane clipper package
// Widths, payload structs, register codes and small selection helpers.
// ---------------------------------------------------------------------------
package tpc_pkg;

  localparam int CW        = 32;          // coordinate width
  localparam int FB        = 16;          // fraction bits of a coordinate
  localparam int RB        = 32;          // config register width
  localparam int SHW       = 16;          // shade width
  localparam int DW        = RB + CW + 2; // signed plane distance width
  localparam int RW        = DW + 1;      // divider remainder width
  localparam int TB        = 32;          // fraction bits of t
  localparam int QW        = TB + 1;      // rounded t width
  localparam int MW        = CW + 1;      // magnitude of a coordinate delta
  localparam int PW        = MW + QW;     // delta times t product width
  localparam int PRW       = RB + CW;     // normal times coordinate product
  localparam int DIV_STEPS = 2;           // quotient bits per divider stage
  localparam int DIV_STG   = TB / DIV_STEPS;
  localparam int ISECT_LAT = DIV_STG + 4;
  localparam int ADDR_W    = 4;

  localparam logic [RB-1:0] NORMAL_X_RST = RB'(0);
  localparam logic [RB-1:0] NORMAL_Y_RST = RB'(0);
  localparam logic [RB-1:0] NORMAL_Z_RST = RB'(65536);
  localparam logic [RB-1:0] OFFSET_RST   = RB'(6554);

  typedef enum logic [1:0] {
    REG_NORMAL_X,
    REG_NORMAL_Y,
    REG_NORMAL_Z,
    REG_PLANE_OFFSET
  } cfg_reg_t;

  typedef enum logic [1:0] {
    VTX_A,
    VTX_B,
    VTX_C
  } vtx_id_t;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] dist_t;
  // element 0 is x, 1 is y, 2 is z
  typedef logic [2:0][CW-1:0] vtx_t;

  typedef struct packed {
    coord_t           a_x;
    coord_t           a_y;
    coord_t           a_z;
    coord_t           b_x;
    coord_t           b_y;
    coord_t           b_z;
    coord_t           c_x;
    coord_t           c_y;
    coord_t           c_z;
    logic [SHW-1:0]   shade;
  } in_item_t;

  typedef struct packed {
    coord_t           out_a_x;
    coord_t           out_a_y;
    coord_t           out_a_z;
    coord_t           out_b_x;
    coord_t           out_b_y;
    coord_t           out_b_z;
    coord_t           out_c_x;
    coord_t           out_c_y;
    coord_t           out_c_z;
    logic [SHW-1:0]   out_shade;
    logic             last;
  } out_item_t;

  // per-triangle context carried alongside the intersection lanes
  typedef struct packed {
    vtx_t           va;
    vtx_t           vb;
    vtx_t           vc;
    logic [SHW-1:0] shade;
    logic [2:0]     mask;   // bit i set: vertex i inside
    vtx_id_t        i0;     // inside vertex of lane 0
    vtx_id_t        i1;     // inside vertex of lane 1
  } ctx_t;

  // item handed to the merge stage
  typedef struct packed {
    logic valid;
    ctx_t ctx;
  } merge_ctl_t;

  function automatic vtx_t mk_vtx(coord_t x, coord_t y, coord_t z);
    return {z, y, x};
  endfunction

  function automatic vtx_t vtx_sel(vtx_t va, vtx_t vb, vtx_t vc, vtx_id_t id);
    vtx_t v;
    case (id)
      VTX_A:   v = va;
      VTX_B:   v = vb;
      VTX_C:   v = vc;
      default: v = va;
    endcase
    return v;
  endfunction

  function automatic out_item_t mk_tri(vtx_t p0, vtx_t p1, vtx_t p2,
                                       logic [SHW-1:0] shade, logic last);
    out_item_t t;
    t.out_a_x   = p0[0];
    t.out_a_y   = p0[1];
    t.out_a_z   = p0[2];
    t.out_b_x   = p1[0];
    t.out_b_y   = p1[1];
    t.out_b_z   = p1[2];
    t.out_c_x   = p2[0];
    t.out_c_y   = p2[1];
    t.out_c_z   = p2[2];
    t.out_shade = shade;
    t.last      = last;
    return t;
  endfunction

endpackage

// File: src/tpc_dist_lane.sv
// ---------------------------------------------------------------------------
// Distance lane
// Signed distance of one vertex to the plane: n.v - offset, two stages.
// ---------------------------------------------------------------------------
module tpc_dist_lane (
  input  logic                      clk,
  input  tpc_pkg::vtx_t             vtx,
  input  logic signed [tpc_pkg::RB-1:0] nrm_x,
  input  logic signed [tpc_pkg::RB-1:0] nrm_y,
  input  logic signed [tpc_pkg::RB-1:0] nrm_z,
  input  logic signed [tpc_pkg::RB-1:0] offset,
  output tpc_pkg::dist_t            vtx_dist
);
  import tpc_pkg::*;

  logic signed [PRW-1:0] prod_x_r, prod_y_r, prod_z_r;
  dist_t                 dist_r;

  // stage 1: one product per axis
  always_ff @(posedge clk) begin
    prod_x_r <= nrm_x * $signed(vtx[0]);
    prod_y_r <= nrm_y * $signed(vtx[1]);
    prod_z_r <= nrm_z * $signed(vtx[2]);
  end

  // stage 2: sum and subtract the offset scaled to the product format
  always_ff @(posedge clk) begin
    dist_r <= DW'(prod_x_r) + DW'(prod_y_r) + DW'(prod_z_r) - (DW'(offset) <<< FB);
  end

  assign vtx_dist = dist_r;

endmodule

// File: src/tpc_isect_lane.sv
// ---------------------------------------------------------------------------
// Intersection lane
// Edge/plane crossing: t = din/(din-dout) by a pipelined restoring divider,
// then in + (out-in)*t rounded half away from zero.
// ---------------------------------------------------------------------------
module tpc_isect_lane (
  input  logic           clk,
  input  tpc_pkg::vtx_t  pin,
  input  tpc_pkg::vtx_t  pout,
  input  tpc_pkg::dist_t din,
  input  tpc_pkg::dist_t dout,
  output tpc_pkg::vtx_t  xpt
);
  import tpc_pkg::*;

  logic [RW-1:0]         rem_r [DIV_STG+1];
  logic [TB-1:0]         quo_r [DIV_STG+1];
  logic [DW-1:0]         den_r [DIV_STG+1];
  logic [2:0][MW-1:0]    mag_r [DIV_STG+1];
  logic [2:0]            sgn_r [DIV_STG+1];
  vtx_t                  pin_r [DIV_STG+1];

  logic [QW-1:0]         q_rnd_r;
  logic [2:0][MW-1:0]    mag_rnd_r;
  logic [2:0]            sgn_rnd_r;
  vtx_t                  pin_rnd_r;

  logic [2:0][PW-1:0]    prod_r;
  logic [2:0]            sgn_mul_r;
  vtx_t                  pin_mul_r;

  vtx_t                  x_r;

  logic [2:0][MW-1:0]    diff_c;
  logic                  rnd_up;
  logic [2:0][CW-1:0]    step_c;

  // coordinate deltas, one bit wider than a coordinate
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff_c[k] = MW'($signed(pout[k])) - MW'($signed(pin[k]));
    end
  end

  // entry stage: denominator, delta sign and magnitude
  always_ff @(posedge clk) begin
    rem_r[0] <= RW'(din);
    quo_r[0] <= '0;
    den_r[0] <= DW'(din - dout);
    pin_r[0] <= pin;
    for (int k = 0; k < 3; k++) begin
      sgn_r[0][k] <= diff_c[k][MW-1];
      mag_r[0][k] <= diff_c[k][MW-1] ? (~diff_c[k] + MW'(1)) : diff_c[k];
    end
  end

  // divider stages, DIV_STEPS quotient bits each
  for (genvar s = 1; s <= DIV_STG; s++) begin : g_div
    logic [RW-1:0] rem_c;
    logic [TB-1:0] quo_c;

    always_comb begin
      rem_c = rem_r[s-1];
      quo_c = quo_r[s-1];
      for (int i = 0; i < DIV_STEPS; i++) begin
        rem_c = rem_c << 1;
        quo_c = quo_c << 1;
        if (rem_c >= RW'(den_r[s-1])) begin
          rem_c    = rem_c - RW'(den_r[s-1]);
          quo_c[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_c;
      quo_r[s] <= quo_c;
      den_r[s] <= den_r[s-1];
      mag_r[s] <= mag_r[s-1];
      sgn_r[s] <= sgn_r[s-1];
      pin_r[s] <= pin_r[s-1];
    end
  end

  // round t half up on the final remainder
  assign rnd_up = ({rem_r[DIV_STG], 1'b0} >= (RW+1)'(den_r[DIV_STG]));

  always_ff @(posedge clk) begin
    q_rnd_r   <= QW'(quo_r[DIV_STG]) + QW'(rnd_up);
    mag_rnd_r <= mag_r[DIV_STG];
    sgn_rnd_r <= sgn_r[DIV_STG];
    pin_rnd_r <= pin_r[DIV_STG];
  end

  // scale each delta by t, plus half a coordinate lsb for rounding
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      prod_r[k] <= PW'(mag_rnd_r[k]) * PW'(q_rnd_r) + (PW'(1) << (TB - 1));
    end
    sgn_mul_r <= sgn_rnd_r;
    pin_mul_r <= pin_rnd_r;
  end

  // apply the delta sign and add to the inside point
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      step_c[k] = prod_r[k][TB +: CW];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      x_r[k] <= pin_mul_r[k] + (sgn_mul_r[k] ? (~step_c[k] + CW'(1)) : step_c[k]);
    end
  end

  assign xpt = x_r;

endmodule

// File: src/tpc_merge.sv
// ---------------------------------------------------------------------------
// Merge stage
// Builds the output triangles from the vertices and the two lane crossings
// and issues up to two transactions per input triangle.
// ---------------------------------------------------------------------------
`include "triangle_plane_clipper_defines.svh"

module tpc_merge (
  input  logic                clk,
  input  logic                rst_n,
  input  tpc_pkg::merge_ctl_t ctl,
  input  tpc_pkg::vtx_t       x0,
  input  tpc_pkg::vtx_t       x1,
  output logic                out_valid,
  output tpc_pkg::out_item_t  out_data
);
  import tpc_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      pend_r, pend_nxt;
  out_item_t pend_tri_r, pend_tri_nxt;
  vtx_t      vi0, vi1;
  logic      item_valid;

  assign item_valid = ctl.valid;
  assign vi0 = vtx_sel(ctl.ctx.va, ctl.ctx.vb, ctl.ctx.vc, ctl.ctx.i0);
  assign vi1 = vtx_sel(ctl.ctx.va, ctl.ctx.vb, ctl.ctx.vc, ctl.ctx.i1);

  // triangle selection by inside mask
  always_comb begin
    out_valid_nxt = 1'b0;
    out_data_nxt  = pend_tri_r;
    pend_nxt      = 1'b0;
    pend_tri_nxt  = pend_tri_r;
    if (pend_r) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = pend_tri_r;
    end else if (item_valid) begin
      case (ctl.ctx.mask)
        3'b000: begin
          out_valid_nxt = 1'b0;
        end
        3'b111: begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = mk_tri(ctl.ctx.va, ctl.ctx.vb, ctl.ctx.vc, ctl.ctx.shade, 1'b1);
        end
        3'b001, 3'b010, 3'b100: begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = mk_tri(vi0, x0, x1, ctl.ctx.shade, 1'b1);
        end
        default: begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = mk_tri(vi0, vi1, x0, ctl.ctx.shade, 1'b0);
          pend_nxt      = 1'b1;
          pend_tri_nxt  = mk_tri(vi1, x0, x1, ctl.ctx.shade, 1'b1);
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    pend_tri_r <= pend_tri_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TPC_ASSERT_NEXT(a_pair_closes, out_valid_r && !out_data_r.last, out_valid_r && out_data_r.last, "first of a pair not followed by the closing triangle")
  `TPC_ASSERT_SAME(a_no_overlap, pend_r, !item_valid, "new triangle arrived while second result pending")
  `TPC_ASSERT_SAME(a_pend_after_first, pend_r, out_valid_r && !out_data_r.last, "pending triangle without a first transaction")

endmodule

// File: src/triangle_plane_clipper.sv
// The first result transaction follows an accepted start through the
// intake, distance, classification, intersection and merge registers; the second
// (two-inside case) comes in the cycle after it. busy is high for the cycle after
// each accepted triangle, as the single result port may carry two triangles.
// Reset: synchronous active-low rst_n clears all valid flags and loads the
// plane registers with normal (0,0,1) and offset 0.1; results cannot stall.
// ---------------------------------------------------------------------------
// Triangle plane clipper top level
// Config registers, three distance lanes, classification, two intersection
// lanes and the merge stage.
// ---------------------------------------------------------------------------
module triangle_plane_clipper (
  input  logic                        clk,
  input  logic                        rst_n,
  // triangle input
  input  logic                        start,
  output logic                        busy,
  input  tpc_pkg::in_item_t           in_data,
  // results
  output logic                        out_valid,
  output tpc_pkg::out_item_t          out_data,
  // config port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tpc_pkg::ADDR_W-1:0]  paddr,
  input  logic [tpc_pkg::RB-1:0]      pwdata,
  output logic [tpc_pkg::RB-1:0]      prdata,
  output logic                        pready
);
  import tpc_pkg::*;

  logic signed [RB-1:0] nrm_x_r, nrm_y_r, nrm_z_r, offset_r;
  cfg_reg_t             reg_sel;
  logic                 cfg_wr;

  logic       busy_r;
  logic       accept;
  logic       vld0_r, vld1_r, vld2_r, cls_vld_r;
  in_item_t   in_r, in1_r, in2_r;
  vtx_t       v0 [3];
  dist_t      vtx_dist [3];

  logic [2:0] mask_c;
  vtx_id_t    l0_in_c, l0_out_c, l1_in_c, l1_out_c;
  ctx_t       cls_ctx_r;
  vtx_t       pin0_r, pout0_r, pin1_r, pout1_r;
  dist_t      din0_r, dout0_r, din1_r, dout1_r;
  vtx_t       va2, vb2, vc2;

  logic       vld_dly_r [ISECT_LAT];
  ctx_t       ctx_dly_r [ISECT_LAT];
  vtx_t       x0, x1;
  merge_ctl_t mctl;

  // ---------------- configuration registers ----------------
  assign reg_sel = cfg_reg_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrm_x_r  <= NORMAL_X_RST;
      nrm_y_r  <= NORMAL_Y_RST;
      nrm_z_r  <= NORMAL_Z_RST;
      offset_r <= OFFSET_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_NORMAL_X:     nrm_x_r  <= pwdata;
        REG_NORMAL_Y:     nrm_y_r  <= pwdata;
        REG_NORMAL_Z:     nrm_z_r  <= pwdata;
        REG_PLANE_OFFSET: offset_r <= pwdata;
        default:          nrm_x_r  <= nrm_x_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_NORMAL_X:     prdata = nrm_x_r;
      REG_NORMAL_Y:     prdata = nrm_y_r;
      REG_NORMAL_Z:     prdata = nrm_z_r;
      REG_PLANE_OFFSET: prdata = offset_r;
      default:          prdata = '0;
    endcase
  end

  // ---------------- intake: a new triangle is taken only while not busy ----------------
  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      vld0_r    <= 1'b0;
      vld1_r    <= 1'b0;
      vld2_r    <= 1'b0;
      cls_vld_r <= 1'b0;
    end else begin
      busy_r    <= accept;
      vld0_r    <= accept;
      vld1_r    <= vld0_r;
      vld2_r    <= vld1_r;
      cls_vld_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
    in1_r <= in_r;
    in2_r <= in1_r;
  end

  // ---------------- distance lanes ----------------
  assign v0[0] = mk_vtx(in_r.a_x, in_r.a_y, in_r.a_z);
  assign v0[1] = mk_vtx(in_r.b_x, in_r.b_y, in_r.b_z);
  assign v0[2] = mk_vtx(in_r.c_x, in_r.c_y, in_r.c_z);

  for (genvar i = 0; i < 3; i++) begin : g_dist
    tpc_dist_lane u_dist (
      .clk      (clk),
      .vtx      (v0[i]),
      .nrm_x    (nrm_x_r),
      .nrm_y    (nrm_y_r),
      .nrm_z    (nrm_z_r),
      .offset   (offset_r),
      .vtx_dist (vtx_dist[i])
    );
  end

  // ---------------- classification ----------------
  assign va2 = mk_vtx(in2_r.a_x, in2_r.a_y, in2_r.a_z);
  assign vb2 = mk_vtx(in2_r.b_x, in2_r.b_y, in2_r.b_z);
  assign vc2 = mk_vtx(in2_r.c_x, in2_r.c_y, in2_r.c_z);
  assign mask_c = {~vtx_dist[2][DW-1], ~vtx_dist[1][DW-1], ~vtx_dist[0][DW-1]};

  // lane endpoints per inside mask; order follows vertex order
  always_comb begin
    l0_in_c  = VTX_A;
    l0_out_c = VTX_B;
    l1_in_c  = VTX_A;
    l1_out_c = VTX_C;
    case (mask_c)
      3'b010: begin
        l0_in_c = VTX_B; l0_out_c = VTX_A; l1_in_c = VTX_B; l1_out_c = VTX_C;
      end
      3'b100: begin
        l0_in_c = VTX_C; l0_out_c = VTX_A; l1_in_c = VTX_C; l1_out_c = VTX_B;
      end
      3'b011: begin
        l0_in_c = VTX_A; l0_out_c = VTX_C; l1_in_c = VTX_B; l1_out_c = VTX_C;
      end
      3'b101: begin
        l0_in_c = VTX_A; l0_out_c = VTX_B; l1_in_c = VTX_C; l1_out_c = VTX_B;
      end
      3'b110: begin
        l0_in_c = VTX_B; l0_out_c = VTX_A; l1_in_c = VTX_C; l1_out_c = VTX_A;
      end
      default: begin
        l0_in_c = VTX_A; l0_out_c = VTX_B; l1_in_c = VTX_A; l1_out_c = VTX_C;
      end
    endcase
  end

  function automatic dist_t dist_sel(dist_t da, dist_t db, dist_t dc, vtx_id_t id);
    dist_t d;
    case (id)
      VTX_A:   d = da;
      VTX_B:   d = db;
      VTX_C:   d = dc;
      default: d = da;
    endcase
    return d;
  endfunction

  always_ff @(posedge clk) begin
    cls_ctx_r.va    <= va2;
    cls_ctx_r.vb    <= vb2;
    cls_ctx_r.vc    <= vc2;
    cls_ctx_r.shade <= in2_r.shade;
    cls_ctx_r.mask  <= mask_c;
    cls_ctx_r.i0    <= l0_in_c;
    cls_ctx_r.i1    <= l1_in_c;
    pin0_r  <= vtx_sel(va2, vb2, vc2, l0_in_c);
    pout0_r <= vtx_sel(va2, vb2, vc2, l0_out_c);
    pin1_r  <= vtx_sel(va2, vb2, vc2, l1_in_c);
    pout1_r <= vtx_sel(va2, vb2, vc2, l1_out_c);
    din0_r  <= dist_sel(vtx_dist[0], vtx_dist[1], vtx_dist[2], l0_in_c);
    dout0_r <= dist_sel(vtx_dist[0], vtx_dist[1], vtx_dist[2], l0_out_c);
    din1_r  <= dist_sel(vtx_dist[0], vtx_dist[1], vtx_dist[2], l1_in_c);
    dout1_r <= dist_sel(vtx_dist[0], vtx_dist[1], vtx_dist[2], l1_out_c);
  end

  // ---------------- intersection lanes ----------------
  tpc_isect_lane u_isect0 (
    .clk  (clk),
    .pin  (pin0_r),
    .pout (pout0_r),
    .din  (din0_r),
    .dout (dout0_r),
    .xpt  (x0)
  );

  tpc_isect_lane u_isect1 (
    .clk  (clk),
    .pin  (pin1_r),
    .pout (pout1_r),
    .din  (din1_r),
    .dout (dout1_r),
    .xpt  (x1)
  );

  // context delay matching the lane latency
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ISECT_LAT; i++) begin
        vld_dly_r[i] <= 1'b0;
      end
    end else begin
      vld_dly_r[0] <= cls_vld_r;
      for (int i = 1; i < ISECT_LAT; i++) begin
        vld_dly_r[i] <= vld_dly_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    ctx_dly_r[0] <= cls_ctx_r;
    for (int i = 1; i < ISECT_LAT; i++) begin
      ctx_dly_r[i] <= ctx_dly_r[i-1];
    end
  end

  // ---------------- merge ----------------
  assign mctl.valid = vld_dly_r[ISECT_LAT-1];
  assign mctl.ctx   = ctx_dly_r[ISECT_LAT-1];

  tpc_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mctl),
    .x0        (x0),
    .x1        (x1),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: tb/sv/tpc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Triangle plane clipper checker
// Watches the triangle, result and config ports, keeps its own copy of the
// plane registers, predicts the clipped triangles of every accepted triangle
// and compares each result transaction against the oldest prediction.
// ---------------------------------------------------------------------------
module tpc_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  tpc_pkg::in_item_t          in_data,
  input  logic                       out_valid,
  input  tpc_pkg::out_item_t         out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tpc_pkg::ADDR_W-1:0] paddr,
  input  logic [tpc_pkg::RB-1:0]     pwdata,
  input  logic                       pready,
  output int                         fail_count,
  output int                         pending
);
  import tpc_pkg::*;

  typedef logic signed [127:0] wide_t;

  logic [RB-1:0] nrm_x, nrm_y, nrm_z, offset;
  out_item_t     tri_q[$];

  assign pending = tri_q.size();

  // signed distance of a vertex from the plane, 2*FB fraction bits
  function automatic wide_t plane_dist(coord_t x, coord_t y, coord_t z);
    wide_t nx, ny, nz, off, vx, vy, vz;
    nx  = $signed(nrm_x);
    ny  = $signed(nrm_y);
    nz  = $signed(nrm_z);
    off = $signed(offset);
    vx  = x;
    vy  = y;
    vz  = z;
    return nx * vx + ny * vy + nz * vz - (off <<< FB);
  endfunction

  // crossing point on the edge from an inside to an outside vertex
  function automatic vtx_t cut_point(vtx_t pin, vtx_t pout, wide_t din, wide_t dout);
    wide_t den, num, q, rem, diff, mag, s, res;
    vtx_t  v;
    den = din - dout;
    num = din <<< TB;
    q   = num / den;
    rem = num - q * den;
    if ((rem <<< 1) >= den) q = q + 1;
    for (int k = 0; k < 3; k++) begin
      diff = wide_t'($signed(pout[k])) - wide_t'($signed(pin[k]));
      mag  = (diff < 0) ? -diff : diff;
      s    = (mag * q + (wide_t'(1) <<< (TB - 1))) >>> TB;
      res  = wide_t'($signed(pin[k])) + ((diff < 0) ? -s : s);
      v[k] = res[CW-1:0];
    end
    return v;
  endfunction

  function automatic out_item_t tri_of(vtx_t p0, vtx_t p1, vtx_t p2,
                                       logic [SHW-1:0] shade, logic fin);
    out_item_t t;
    t = {p0[0], p0[1], p0[2], p1[0], p1[1], p1[2], p2[0], p2[1], p2[2], shade, fin};
    return t;
  endfunction

  task automatic clip_triangle(in_item_t it);
    vtx_t  v[3];
    wide_t d[3];
    int    ins[3], outs[3];
    int    n_in, n_out;
    vtx_t  x0, x1;
    n_in  = 0;
    n_out = 0;
    v[0] = {it.a_z, it.a_y, it.a_x};
    v[1] = {it.b_z, it.b_y, it.b_x};
    v[2] = {it.c_z, it.c_y, it.c_x};
    for (int i = 0; i < 3; i++) begin
      d[i] = plane_dist(v[i][0], v[i][1], v[i][2]);
      if (d[i] >= 0) begin
        ins[n_in] = i;
        n_in++;
      end else begin
        outs[n_out] = i;
        n_out++;
      end
    end
    case (n_in)
      3: tri_q.insert(tri_q.size(), tri_of(v[0], v[1], v[2], it.shade, 1'b1));
      1: begin
        x0 = cut_point(v[ins[0]], v[outs[0]], d[ins[0]], d[outs[0]]);
        x1 = cut_point(v[ins[0]], v[outs[1]], d[ins[0]], d[outs[1]]);
        tri_q.insert(tri_q.size(), tri_of(v[ins[0]], x0, x1, it.shade, 1'b1));
      end
      2: begin
        x0 = cut_point(v[ins[0]], v[outs[0]], d[ins[0]], d[outs[0]]);
        x1 = cut_point(v[ins[1]], v[outs[0]], d[ins[1]], d[outs[0]]);
        tri_q.insert(tri_q.size(), tri_of(v[ins[0]], v[ins[1]], x0, it.shade, 1'b0));
        tri_q.insert(tri_q.size(), tri_of(v[ins[1]], x0, x1, it.shade, 1'b1));
      end
      default: ;  // fully outside, nothing emitted
    endcase
  endtask

  task automatic check_field(string name, logic [CW-1:0] exp_v, logic [CW-1:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t: %s mismatch expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      nrm_x      <= NORMAL_X_RST;
      nrm_y      <= NORMAL_Y_RST;
      nrm_z      <= NORMAL_Z_RST;
      offset     <= OFFSET_RST;
      fail_count = 0;
      tri_q.delete();
    end else begin
      // register write
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_t'(paddr[3:2]))
          REG_NORMAL_X:     nrm_x  <= pwdata;
          REG_NORMAL_Y:     nrm_y  <= pwdata;
          REG_NORMAL_Z:     nrm_z  <= pwdata;
          REG_PLANE_OFFSET: offset <= pwdata;
          default: ;
        endcase
      end
      // accepted triangle transaction
      if (start && !busy) clip_triangle(in_data);
      // result transaction
      if (out_valid) begin
        if (tri_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result expected none actual %h", $time, out_data);
        end else begin
          out_item_t e;
          e = tri_q.pop_front();
          check_field("out_a_x", e.out_a_x, out_data.out_a_x);
          check_field("out_a_y", e.out_a_y, out_data.out_a_y);
          check_field("out_a_z", e.out_a_z, out_data.out_a_z);
          check_field("out_b_x", e.out_b_x, out_data.out_b_x);
          check_field("out_b_y", e.out_b_y, out_data.out_b_y);
          check_field("out_b_z", e.out_b_z, out_data.out_b_z);
          check_field("out_c_x", e.out_c_x, out_data.out_c_x);
          check_field("out_c_y", e.out_c_y, out_data.out_c_y);
          check_field("out_c_z", e.out_c_z, out_data.out_c_z);
          check_field("out_shade", CW'(e.out_shade), CW'(out_data.out_shade));
          check_field("last", CW'(e.last), CW'(out_data.last));
        end
      end
    end
  end

endmodule

// File: tb/sv/tb_triangle_plane_clipper.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Triangle plane clipper testbench
// Directed triangles for every inside/outside pattern and the field extremes,
// then random triangles over several plane settings and sender idle rates.
// The checker module predicts and compares; this module drives and decides.
// ---------------------------------------------------------------------------
module tb_triangle_plane_clipper;
  import tpc_pkg::*;

  localparam int WATCHDOG  = 4000;
  localparam int DRAIN_GAP = 40;
  localparam int PHASES    = 5;
  localparam int PER_PHASE = 290;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  in_item_t            in_data = '0;
  logic                out_valid;
  out_item_t           out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [RB-1:0]       pwdata = '0;
  logic [RB-1:0]       prdata;
  logic                pready;
  int                  fail_count;
  int                  pending;
  int                  idle_cycles = 0;
  int                  idle_pct = 0;

  always #1 clk = ~clk;

  triangle_plane_clipper dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  tpc_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending(pending)
  );

  // watchdog: cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("tb_triangle_plane_clipper NOT OK");
      $finish;
    end
  end

  // present one triangle and hold it until taken; start stays high unless a gap follows
  task automatic send_tri(in_item_t it);
    logic take;
    start   <= 1'b1;
    in_data <= it;
    do begin
      @(negedge clk);
      take = !busy;
      @(posedge clk);
    end while (!take);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  // stop sending and let every outstanding result drain
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic reg_write(cfg_reg_t idx, logic [RB-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_plane(logic [RB-1:0] nx, logic [RB-1:0] ny, logic [RB-1:0] nz,
                           logic [RB-1:0] off);
    reg_write(REG_NORMAL_X, nx);
    reg_write(REG_NORMAL_Y, ny);
    reg_write(REG_NORMAL_Z, nz);
    reg_write(REG_PLANE_OFFSET, off);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(5))
      0, 1:    return coord_t'($urandom);
      2:       return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      3:       return coord_t'($urandom_range(32'h0000_3000, 32'h0000_2000));
      default: return coord_t'(int'($urandom_range(32'h0020_0000)) - 32'h0010_0000);
    endcase
  endfunction

  function automatic in_item_t rand_tri();
    in_item_t t;
    t = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
         rand_coord(), rand_coord(), rand_coord(), rand_coord(), 16'($urandom)};
    return t;
  endfunction

  // default plane is z = 0.1; pick z per vertex to set inside/outside
  function automatic in_item_t z_tri(coord_t za, coord_t zb, coord_t zc,
                                     coord_t xy, logic [SHW-1:0] sh);
    in_item_t t;
    t = {xy, -xy, za, -xy, xy, zb, coord_t'(32'h0001_8000), xy, zc, sh};
    return t;
  endfunction

  localparam coord_t ZIN  = 32'sh0001_0000;
  localparam coord_t ZOUT = -32'sh0002_0000;
  localparam coord_t ZON  = 32'sd6554;
  localparam coord_t CMAX = 32'sh7FFF_FFFF;
  localparam coord_t CMIN = 32'sh8000_0000;

  logic [RB-1:0] plane_set[PHASES][4] = '{
    '{32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_199A},
    '{32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0000_0000},
    '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000},
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF},
    '{32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_2345}
  };
  int phase_idle[PHASES] = '{0, 47, 28, 0, 47};

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed triangles under the reset plane
    send_tri(z_tri(ZOUT, ZOUT, ZOUT, 32'sh0, 16'h0000));
    send_tri(z_tri(ZIN, ZIN, ZIN, 32'sh0001_0000, 16'hFFFF));
    send_tri(z_tri(ZIN, ZOUT, ZOUT, 32'sh0003_0000, 16'h1234));
    send_tri(z_tri(ZOUT, ZIN, ZOUT, 32'sh0003_0000, 16'h5678));
    send_tri(z_tri(ZOUT, ZOUT, ZIN, -32'sh0005_0000, 16'h9ABC));
    send_tri(z_tri(ZIN, ZIN, ZOUT, 32'sh0002_0000, 16'h0001));
    send_tri(z_tri(ZIN, ZOUT, ZIN, -32'sh0002_0000, 16'h8000));
    send_tri(z_tri(ZOUT, ZIN, ZIN, 32'sh0007_1234, 16'h7FFF));
    send_tri(z_tri(ZON, ZOUT, ZOUT, 32'sh0001_0000, 16'h0F0F));  // on plane, t = 0
    send_tri(z_tri(ZON, ZON, ZOUT, 32'sh0001_0000, 16'hF0F0));
    send_tri(z_tri(ZON, ZON, ZON, 32'sh0, 16'hAAAA));
    send_tri(z_tri(CMAX, CMIN, CMIN, CMAX, 16'h5555));
    send_tri(z_tri(CMIN, CMAX, CMAX, CMIN, 16'hFFFF));
    send_tri(z_tri(CMAX, CMAX, CMIN, CMIN, 16'h0000));
    send_tri(z_tri(ZON - 1, ZON, ZON - 1, CMAX, 16'h1111));
    send_tri({CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN, 16'hFFFF});
    send_tri({CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 32'sh0, 32'sh0, 32'sh0, 16'h0000});
    drain();

    // random phases over several plane settings; each drain empties the pipeline
    for (int p = 0; p < PHASES; p++) begin
      set_plane(plane_set[p][0], plane_set[p][1], plane_set[p][2], plane_set[p][3]);
      idle_pct = phase_idle[p];
      for (int n = 0; n < PER_PHASE; n++) begin
        // stretches of back-to-back triangles inside idle phases
        if (phase_idle[p] > 0) idle_pct = ((n / 40) % 3 == 2) ? 0 : phase_idle[p];
        send_tri(rand_tri());
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("tb_triangle_plane_clipper OK");
    end else begin
      $display("tb_triangle_plane_clipper NOT OK");
    end
    $finish;
  end

endmodule
